[hw/rtl/lcbb_pkg.sv]
package lcbb_pkg;

   localparam int KEY_W    = 64;
   localparam int SIZE_W   = 17;
   localparam int BYTES_W  = 24;
   localparam int SLOT_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [BYTES_W-1:0] BYTE_BUDGET_RST = 24'd10490000;
   localparam logic [SIZE_W-1:0]  MAX_OBJECT_RST  = 17'd102400;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_BUDGET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OBJECT  = 1'd1;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_MISS     = 3'd0,
      KIND_HIT      = 3'd1,
      KIND_EVICTED  = 3'd2,
      KIND_PLACED   = 3'd3,
      KIND_REJECTED = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS,
      ST_SCAN,
      ST_HIT,
      ST_TOUCH,
      ST_MISS,
      ST_REJECT,
      ST_EVICT,
      ST_DECR,
      ST_PLACE
   } fsm_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_W-1:0]    key;
      logic [SIZE_W-1:0]   obj_bytes;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   slot;
      logic [SIZE_W-1:0]   size_out;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [SIZE_W-1:0]   size;
   } ent_type;

endpackage

[hw/rtl/lru_cache_with_byte_budget.sv]
// Fully associative LRU object table of ENTRIES slots (key, size, recency rank) held in two
// synchronous RAMs (key/size and rank) with a valid bit per slot in flops, plus a running byte
// total and entry count. Requests are handled one at a time by a sequencer that walks the RAMs
// one slot per cycle. A lookup runs a match walk and a result step, and on a hit then a rank
// update walk. An insert that fits in a free slot goes straight to its result, as does a
// rejected one; each eviction adds a min-rank walk, a result and a rank decrement walk.
// Result steps wait on rsp_ready. The result register lets the last result wait on rsp_ready
// while the next request is accepted. Configuration writes are taken in any cycle and must
// only be issued while the block is idle.
module lru_cache_with_byte_budget #(
   parameter int ENTRIES = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lcbb_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lcbb_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lcbb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcbb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   lcbb_pkg::fsm_type state_ff, state_in;
   lcbb_pkg::req_type req_ff, req_in;
   lcbb_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0] scan_ff, scan_in;
   logic issue_ff, issue_in;
   logic proc_ff, proc_in;
   logic [IW-1:0] proc_idx_ff, proc_idx_in;

   logic found_ff, found_in;
   logic [IW-1:0] best_slot_ff, best_slot_in;
   logic [IW-1:0] best_rank_ff, best_rank_in;
   logic [lcbb_pkg::SIZE_W-1:0] best_size_ff, best_size_in;
   logic [IW-1:0] place_slot_ff, place_slot_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [lcbb_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] evict_cnt_ff, evict_cnt_in;

   logic [lcbb_pkg::BYTES_W-1:0] budget_ff, budget_in;
   logic [lcbb_pkg::SIZE_W-1:0] max_obj_ff, max_obj_in;

   lcbb_pkg::ent_type ent_mem [ENTRIES];
   logic [IW-1:0] rank_mem [ENTRIES];
   lcbb_pkg::ent_type ent_rd_ff;
   logic [IW-1:0] rank_rd_ff;

   logic ent_we;
   logic rank_we;
   logic [IW-1:0] rank_waddr;
   logic [IW-1:0] rank_wdata;

   logic out_free;
   logic pass_done;
   logic cur_valid;
   logic any_free;
   logic [IW-1:0] free_slot;
   logic reject;
   logic fits;
   logic need_more;
   logic [lcbb_pkg::BYTES_W:0] sum_bytes;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pass_done = proc_ff && (proc_idx_ff == LAST_IDX);
   assign cur_valid = valid_ff[proc_idx_ff];
   assign sum_bytes = {1'b0, bytes_ff} + (lcbb_pkg::BYTES_W + 1)'(req_ff.obj_bytes);
   assign fits      = (sum_bytes <= {1'b0, budget_ff}) && (held_ff < CW'(ENTRIES));
   assign need_more = (sum_bytes > {1'b0, budget_ff}) && (evict_cnt_ff < CW'(ENTRIES));
   assign reject    = (req_ff.obj_bytes > max_obj_ff)
                   || (lcbb_pkg::BYTES_W'(req_ff.obj_bytes) > budget_ff);

   always_comb begin
      any_free  = 1'b0;
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free  = 1'b1;
            free_slot = IW'(i);
         end
      end
   end

   // match or min-rank search; found flag cleared outside the scan
   always_comb begin
      found_in     = 1'b0;
      best_slot_in = best_slot_ff;
      best_rank_in = best_rank_ff;
      best_size_in = best_size_ff;
      if (state_ff == lcbb_pkg::ST_SCAN) begin
         found_in = found_ff;
         if (proc_ff && cur_valid) begin
            if (req_ff.op == lcbb_pkg::OP_LOOKUP) begin
               if (ent_rd_ff.key == req_ff.key) begin
                  found_in     = 1'b1;
                  best_slot_in = proc_idx_ff;
                  best_rank_in = rank_rd_ff;
                  best_size_in = ent_rd_ff.size;
               end
            end else if (!found_ff || rank_rd_ff < best_rank_ff) begin
               found_in     = 1'b1;
               best_slot_in = proc_idx_ff;
               best_rank_in = rank_rd_ff;
               best_size_in = ent_rd_ff.size;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcbb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.op == lcbb_pkg::OP_INSERT) ? lcbb_pkg::ST_INS
                                                                : lcbb_pkg::ST_SCAN;
            end
         end
         lcbb_pkg::ST_INS: begin
            if (reject) begin
               state_in = lcbb_pkg::ST_REJECT;
            end else if (fits && any_free) begin
               state_in = lcbb_pkg::ST_PLACE;
            end else begin
               state_in = lcbb_pkg::ST_SCAN;
            end
         end
         lcbb_pkg::ST_SCAN: begin
            if (pass_done) begin
               if (req_ff.op == lcbb_pkg::OP_LOOKUP) begin
                  state_in = found_in ? lcbb_pkg::ST_HIT : lcbb_pkg::ST_MISS;
               end else if (found_in) begin
                  state_in = lcbb_pkg::ST_EVICT;
               end else begin
                  state_in = (evict_cnt_ff != '0) ? lcbb_pkg::ST_PLACE : lcbb_pkg::ST_REJECT;
               end
            end
         end
         lcbb_pkg::ST_HIT: begin
            if (out_free) state_in = lcbb_pkg::ST_TOUCH;
         end
         lcbb_pkg::ST_TOUCH: begin
            if (pass_done) state_in = lcbb_pkg::ST_IDLE;
         end
         lcbb_pkg::ST_MISS, lcbb_pkg::ST_REJECT, lcbb_pkg::ST_PLACE: begin
            if (out_free) state_in = lcbb_pkg::ST_IDLE;
         end
         lcbb_pkg::ST_EVICT: begin
            if (out_free) state_in = lcbb_pkg::ST_DECR;
         end
         lcbb_pkg::ST_DECR: begin
            if (pass_done) state_in = need_more ? lcbb_pkg::ST_SCAN : lcbb_pkg::ST_PLACE;
         end
         default: state_in = lcbb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      scan_in       = scan_ff;
      issue_in      = 1'b0;
      proc_in       = 1'b0;
      proc_idx_in   = scan_ff;
      place_slot_in = place_slot_ff;
      valid_in      = valid_ff;
      bytes_in      = bytes_ff;
      held_in       = held_ff;
      evict_cnt_in  = evict_cnt_ff;
      budget_in     = budget_ff;
      max_obj_in    = max_obj_ff;
      ent_we        = 1'b0;
      rank_we       = 1'b0;
      rank_waddr    = proc_idx_ff;
      rank_wdata    = rank_rd_ff - 1'b1;
      req_ready     = (state_ff == lcbb_pkg::ST_IDLE);
      csr_ready     = 1'b1;

      if (csr_valid) begin
         case (csr_index)
            lcbb_pkg::CSR_BYTE_BUDGET: budget_in = csr_wdata;
            lcbb_pkg::CSR_MAX_OBJECT:  max_obj_in = csr_wdata[lcbb_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end

      // table walk: one read issued per cycle, processed in the cycle after it is issued
      if (state_ff inside {lcbb_pkg::ST_SCAN, lcbb_pkg::ST_DECR, lcbb_pkg::ST_TOUCH}) begin
         proc_in  = issue_ff;
         issue_in = issue_ff && (scan_ff != LAST_IDX);
         if (issue_ff && scan_ff != LAST_IDX) scan_in = scan_ff + 1'b1;
      end

      case (state_ff)
         lcbb_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               evict_cnt_in = '0;
            end
         end
         lcbb_pkg::ST_INS: begin
            place_slot_in = free_slot;
         end
         lcbb_pkg::ST_HIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: lcbb_pkg::KIND_HIT,
                          slot: lcbb_pkg::SLOT_W'(best_slot_ff),
                          size_out: best_size_ff, last: 1'b1};
            end
         end
         lcbb_pkg::ST_TOUCH: begin
            if (proc_ff) begin
               if (proc_idx_ff == best_slot_ff) begin
                  rank_we    = 1'b1;
                  rank_wdata = IW'(held_ff - 1'b1);
               end else if (cur_valid && rank_rd_ff > best_rank_ff) begin
                  rank_we = 1'b1;
               end
            end
         end
         lcbb_pkg::ST_MISS, lcbb_pkg::ST_REJECT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: (state_ff == lcbb_pkg::ST_MISS) ? lcbb_pkg::KIND_MISS
                                                                : lcbb_pkg::KIND_REJECTED,
                          slot: '0, size_out: '0, last: 1'b1};
            end
         end
         lcbb_pkg::ST_EVICT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: lcbb_pkg::KIND_EVICTED,
                          slot: lcbb_pkg::SLOT_W'(best_slot_ff),
                          size_out: best_size_ff, last: 1'b0};
               valid_in[best_slot_ff] = 1'b0;
               bytes_in      = bytes_ff - lcbb_pkg::BYTES_W'(best_size_ff);
               if (held_ff != '0) held_in = held_ff - 1'b1;
               evict_cnt_in  = evict_cnt_ff + 1'b1;
               place_slot_in = best_slot_ff;
            end
         end
         lcbb_pkg::ST_DECR: begin
            if (proc_ff && cur_valid && rank_rd_ff > best_rank_ff) rank_we = 1'b1;
         end
         lcbb_pkg::ST_PLACE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: lcbb_pkg::KIND_PLACED,
                          slot: lcbb_pkg::SLOT_W'(place_slot_ff),
                          size_out: '0, last: 1'b1};
               valid_in[place_slot_ff] = 1'b1;
               bytes_in   = bytes_ff + lcbb_pkg::BYTES_W'(req_ff.obj_bytes);
               held_in    = held_ff + 1'b1;
               ent_we     = 1'b1;
               rank_we    = 1'b1;
               rank_waddr = place_slot_ff;
               rank_wdata = held_ff[IW-1:0];
            end
         end
         default: ;
      endcase

      if (state_in != state_ff
          && (state_in inside {lcbb_pkg::ST_SCAN, lcbb_pkg::ST_DECR, lcbb_pkg::ST_TOUCH})) begin
         scan_in  = '0;
         issue_in = 1'b1;
         proc_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[place_slot_ff] <= '{key: req_ff.key, size: req_ff.obj_bytes};
      if (rank_we) rank_mem[rank_waddr] <= rank_wdata;
      ent_rd_ff  <= ent_mem[scan_ff];
      rank_rd_ff <= rank_mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcbb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         proc_ff      <= 1'b0;
         found_ff     <= 1'b0;
         valid_ff     <= '0;
         bytes_ff     <= '0;
         held_ff      <= '0;
         evict_cnt_ff <= '0;
         budget_ff    <= lcbb_pkg::BYTE_BUDGET_RST;
         max_obj_ff   <= lcbb_pkg::MAX_OBJECT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         proc_ff      <= proc_in;
         found_ff     <= found_in;
         valid_ff     <= valid_in;
         bytes_ff     <= bytes_in;
         held_ff      <= held_in;
         evict_cnt_ff <= evict_cnt_in;
         budget_ff    <= budget_in;
         max_obj_ff   <= max_obj_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      scan_ff       <= scan_in;
      proc_idx_ff   <= proc_idx_in;
      best_slot_ff  <= best_slot_in;
      best_rank_ff  <= best_rank_in;
      best_size_ff  <= best_size_in;
      place_slot_ff <= place_slot_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/lcbb_checker.sv]
module lcbb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lcbb_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_nonlast_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.kind == lcbb_pkg::KIND_EVICTED)
      else $error("non-final response is not an eviction");

   a_busy_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("request accepted while an insert is still evicting");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == lcbb_pkg::KIND_MISS
                    || rsp_data.kind == lcbb_pkg::KIND_REJECTED)
      |-> rsp_data.slot == '0 && rsp_data.size_out == '0)
      else $error("miss or reject carries slot or size");

endmodule

bind lru_cache_with_byte_budget lcbb_checker u_lcbb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
